### rtl/core/mpr_pkg.sv
// Shared types, constants and helper functions for the max pooling core.
// No dependencies; every other file of the block imports this package.
package mpr_pkg;

  localparam int VAL_W    = 16;
  localparam int CNT_W    = 10;
  localparam int DIM_W    = 11;
  localparam int POOL_W   = 4;
  localparam int PCNT_W   = 17;
  localparam int PLANE_W  = 16;
  localparam int OFF_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MAX_POOL   = 8;
  localparam int MAX_DIM    = 1024;
  localparam int Q_DEPTH    = 8;
  localparam int Q_AW       = 3;
  localparam int Q_CW       = 4;
  localparam int DEF_MAX_COLS     = 1024;
  localparam int DEF_MASK_ENTRIES = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 3'd4;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  plane_rows;
    logic [DIM_W-1:0]  plane_cols;
    logic [POOL_W-1:0] pool_rows;
    logic [POOL_W-1:0] pool_cols;
    logic [PCNT_W-1:0] plane_count;
  } cfg_t;

  // One queued command: a finished forward window or a backward gradient.
  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        row;
    logic [CNT_W-1:0]        col;
    logic [OFF_W-1:0]        off;
  } cmd_t;

  // Ceiling of 2^16 / p: a multiply and shift by 16 gives an exact
  // quotient for every 10-bit dividend.
  function automatic logic [16:0] pool_recip(input logic [POOL_W-1:0] p);
    logic [16:0] r;
    unique case (p)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/mpr_if.sv
// Valid/ready channel interfaces for the pooling input and result streams.
// Depends on mpr_pkg for field widths.
interface mpr_in_if;
  import mpr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic                    first;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, mode, first, value, input ready);
  modport sink   (input valid, mode, first, value, output ready);
endinterface

interface mpr_out_if;
  import mpr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    result_mode;
  logic signed [VAL_W-1:0] result_value;
  logic [CNT_W-1:0]        out_row;
  logic [CNT_W-1:0]        out_col;
  logic [OFF_W-1:0]        window_offset;
  logic                    is_winner;
  logic                    last;
  modport source (output valid, result_mode, result_value, out_row, out_col,
                  window_offset, is_winner, last, input ready);
  modport sink   (input valid, result_mode, result_value, out_row, out_col,
                  window_offset, is_winner, last, output ready);
endinterface

### rtl/core/mpr_front.sv
// Front end: accepts items, walks the position counters, finds window
// coordinates, keeps the running maxima and winner mask, and issues commands.
// Depends on mpr_pkg and mpr_in_if.
module mpr_front #(
  parameter int MAX_COLS     = mpr_pkg::DEF_MAX_COLS,
  parameter int MASK_ENTRIES = mpr_pkg::DEF_MASK_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mpr_in_if.sink                    in_ch,
  input  mpr_pkg::cfg_t             cfg,
  input  logic [mpr_pkg::Q_CW-1:0]  q_count,
  output logic                      push,
  output mpr_pkg::cmd_t             cmd
);
  import mpr_pkg::*;

  localparam int PW  = (MASK_ENTRIES > 1) ? $clog2(MASK_ENTRIES) : 1;
  localparam int MCW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [24:0] RM = 25'(((64'd1 << 24) + 64'(MAX_COLS) - 64'd1) / 64'(MAX_COLS));
  localparam logic [12:0] MC13 = 13'(MAX_COLS);
  localparam logic [PW-1:0] POS_LAST = PW'(MASK_ENTRIES - 1);

  typedef struct packed {
    logic                    mode;
    logic                    first;
    logic                    wrap;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        row;
    logic [CNT_W-1:0]        col;
    logic [CNT_W-1:0]        qc;
    logic [CNT_W-1:0]        qr;
    logic [CNT_W-1:0]        qm;
    logic [2:0]              wc;
    logic [2:0]              wr;
    logic [CNT_W-1:0]        oc;
    logic [OFF_W-1:0]        off;
    logic                    emit;
    logic [PW-1:0]           pos;
  } stg_t;

  logic [CNT_W-1:0]   row_r, col_r;
  logic [PLANE_W-1:0] plane_r;
  logic [PW-1:0]      pos_r;
  logic [3:0]         vld_r;
  stg_t s0_r, s1_r, s2_r, s3_r;
  stg_t s0_nxt, s1_nxt, s2_nxt, s3_nxt;

  logic [VAL_W+OFF_W-1:0] rmax_mem [MAX_COLS];
  logic [OFF_W-1:0]       mask_mem [MASK_ENTRIES];
  logic [VAL_W+OFF_W-1:0] rm_q;
  logic [OFF_W-1:0]       mk_q;

  logic                   rb_v_r, mb_v_r;
  logic [MCW-1:0]         rb_idx_r;
  logic [VAL_W+OFF_W-1:0] rb_dat_r;
  logic [PW-1:0]          mb_pos_r;
  logic [OFF_W-1:0]       mb_dat_r;

  logic                accept;
  logic [CNT_W-1:0]    col_b, row_b;
  logic [PLANE_W-1:0]  plane_b;
  logic                hit_c, hit_r, wrap_p;
  logic [14:0]         bc_prod, br_prod;
  logic [2:0]          inflight;
  logic [4:0]          credit;

  assign inflight = 3'($countones(vld_r));
  assign credit   = 5'(q_count) + 5'(inflight);
  assign in_ch.ready = (credit < 5'(Q_DEPTH));
  assign accept = in_ch.valid && in_ch.ready;

  // Position counters, advanced at acceptance.
  always_comb begin
    col_b   = in_ch.first ? '0 : col_r;
    row_b   = in_ch.first ? '0 : row_r;
    plane_b = in_ch.first ? '0 : plane_r;
    bc_prod = (15'(col_b) + 15'd2) * 15'(cfg.pool_cols);
    br_prod = (15'(row_b) + 15'd2) * 15'(cfg.pool_rows);
    if (in_ch.mode == MODE_FWD) begin
      hit_c = (11'(col_b) + 11'd1) >= cfg.plane_cols;
      hit_r = (11'(row_b) + 11'd1) >= cfg.plane_rows;
    end else begin
      // Output grid limit floor(P/p), at least one, is reached at col+1.
      hit_c = 15'(cfg.plane_cols) < bc_prod;
      hit_r = 15'(cfg.plane_rows) < br_prod;
    end
    wrap_p = hit_c && hit_r && ((17'(plane_b) + 17'd1) >= cfg.plane_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      plane_r <= '0;
    end else if (accept) begin
      if (!hit_c) begin
        col_r <= col_b + 10'd1;
        row_r <= row_b;
        plane_r <= plane_b;
      end else begin
        col_r <= '0;
        if (!hit_r) begin
          row_r   <= row_b + 10'd1;
          plane_r <= plane_b;
        end else begin
          row_r   <= '0;
          plane_r <= wrap_p ? '0 : plane_b + 16'd1;
        end
      end
    end
  end

  logic [26:0] pc_prod, pr_prod;
  logic [CNT_W-1:0] tc, tr;
  logic [34:0] qm_prod;
  logic [22:0] om_prod;
  logic [PW-1:0] pos_eff, pos_inc;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.mode  = in_ch.mode;
    s0_nxt.first = in_ch.first;
    s0_nxt.wrap  = wrap_p;
    s0_nxt.value = in_ch.value;
    s0_nxt.row   = row_b;
    s0_nxt.col   = col_b;

    // Quotients by the window size.
    s1_nxt  = s0_r;
    pc_prod = 27'(s0_r.col) * 27'(pool_recip(cfg.pool_cols));
    pr_prod = 27'(s0_r.row) * 27'(pool_recip(cfg.pool_rows));
    s1_nxt.qc = pc_prod[25:16];
    s1_nxt.qr = pr_prod[25:16];

    // Offsets inside the window, and the quotient by the column store depth.
    s2_nxt = s1_r;
    tc = 10'(s1_r.qc * 10'(cfg.pool_cols));
    tr = 10'(s1_r.qr * 10'(cfg.pool_rows));
    s2_nxt.wc = 3'(s1_r.col - tc);
    s2_nxt.wr = 3'(s1_r.row - tr);
    qm_prod   = 35'(s1_r.qc) * 35'(RM);
    s2_nxt.qm = 10'(qm_prod >> 24);

    s3_nxt  = s2_r;
    om_prod = 23'(s2_r.qm) * 23'(MC13);
    s3_nxt.oc  = s2_r.qc - om_prod[9:0];
    s3_nxt.off = 6'(7'(s2_r.wr) * 7'(cfg.pool_cols)) + 6'(s2_r.wc);
    s3_nxt.emit = (s2_r.mode == MODE_FWD)
                  && (s2_r.wr == 3'(cfg.pool_rows - 4'd1))
                  && (s2_r.wc == 3'(cfg.pool_cols - 4'd1))
                  && (11'(s2_r.col) < cfg.plane_cols)
                  && (11'(s2_r.row) < cfg.plane_rows);
    pos_eff = s2_r.first ? '0 : pos_r;
    pos_inc = (pos_eff == POS_LAST) ? '0 : pos_eff + PW'(1);
    s3_nxt.pos = pos_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pos_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], accept};
      if (vld_r[2]) begin
        if (s2_r.wrap)
          pos_r <= '0;
        else if (s2_r.mode == MODE_BWD || s3_nxt.emit)
          pos_r <= pos_inc;
        else
          pos_r <= pos_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  // Window update: a write made at the same edge as the read is not yet in the read data.
  logic [MCW-1:0]          s3_idx;
  logic [VAL_W+OFF_W-1:0]  cur;
  logic signed [VAL_W-1:0] cur_max, new_max;
  logic [OFF_W-1:0]        new_arg, win;
  logic                    fwd_wr, mask_wr;

  always_comb begin
    s3_idx  = MCW'(s3_r.oc);
    cur     = (rb_v_r && rb_idx_r == s3_idx) ? rb_dat_r : rm_q;
    cur_max = cur[VAL_W+OFF_W-1:OFF_W];
    if (s3_r.off == '0 || s3_r.value > cur_max) begin
      new_max = s3_r.value;
      new_arg = s3_r.off;
    end else begin
      new_max = cur_max;
      new_arg = cur[OFF_W-1:0];
    end
    win     = (mb_v_r && mb_pos_r == s3_r.pos) ? mb_dat_r : mk_q;
    fwd_wr  = vld_r[3] && (s3_r.mode == MODE_FWD);
    mask_wr = fwd_wr && s3_r.emit;
    push    = vld_r[3] && (s3_r.mode == MODE_BWD || s3_r.emit);
    cmd.mode = s3_r.mode;
    if (s3_r.mode == MODE_FWD) begin
      cmd.value = new_max;
      cmd.row   = s3_r.qr;
      cmd.col   = s3_r.oc;
      cmd.off   = new_arg;
    end else begin
      cmd.value = s3_r.value;
      cmd.row   = s3_r.row;
      cmd.col   = s3_r.col;
      cmd.off   = win;
    end
  end

  always_ff @(posedge clk) begin
    rm_q <= rmax_mem[MCW'(s3_nxt.oc)];
    mk_q <= mask_mem[pos_eff];
    if (fwd_wr)
      rmax_mem[s3_idx] <= {new_max, new_arg};
    if (mask_wr)
      mask_mem[s3_r.pos] <= new_arg;
    rb_idx_r <= s3_idx;
    rb_dat_r <= {new_max, new_arg};
    mb_pos_r <= s3_r.pos;
    mb_dat_r <= new_arg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_v_r <= 1'b0;
      mb_v_r <= 1'b0;
    end else begin
      rb_v_r <= fwd_wr;
      mb_v_r <= mask_wr;
    end
  end

endmodule

### rtl/core/mpr_queue.sv
// Command queue between the front end and the result sequencer.
// Depends on mpr_pkg for the command type and depth.
module mpr_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  mpr_pkg::cmd_t             push_cmd,
  input  logic                      pop,
  output mpr_pkg::cmd_t             head_cmd,
  output logic                      not_empty,
  output logic [mpr_pkg::Q_CW-1:0]  count
);
  import mpr_pkg::*;

  cmd_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] head_r, tail_r;
  logic [Q_CW-1:0] count_r;

  assign head_cmd  = entry_r[head_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push)
      entry_r[tail_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push)
        tail_r <= tail_r + Q_AW'(1);
      if (pop)
        head_r <= head_r + Q_AW'(1);
      if (push && !pop)
        count_r <= count_r + Q_CW'(1);
      else if (pop && !push)
        count_r <= count_r - Q_CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < Q_CW'(Q_DEPTH) || pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("command queue count out of range");

endmodule

### rtl/core/mpr_back.sv
// Result sequencer: turns queued commands into result transfers, one per
// forward window and one per window element for a backward gradient.
// Depends on mpr_pkg and mpr_out_if.
module mpr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mpr_pkg::cfg_t cfg,
  input  mpr_pkg::cmd_t head_cmd,
  input  logic          head_valid,
  output logic          pop,
  mpr_out_if.source     out_ch
);
  import mpr_pkg::*;

  logic [OFF_W-1:0]        k_r;
  logic                    out_valid_r;
  logic                    mode_r, win_r, last_r;
  logic signed [VAL_W-1:0] value_r;
  logic [CNT_W-1:0]        row_r, col_r;
  logic [OFF_W-1:0]        off_r;

  logic [7:0] total;
  logic       load, last_k, hit;

  always_comb begin
    total  = 8'(cfg.pool_rows) * 8'(cfg.pool_cols);
    load   = head_valid && (!out_valid_r || out_ch.ready);
    last_k = (head_cmd.mode == MODE_FWD) || (8'(k_r) == total - 8'd1);
    hit    = (k_r == head_cmd.off);
    pop    = load && last_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
      if (load)
        k_r <= last_k ? '0 : k_r + OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= head_cmd.mode;
      row_r  <= head_cmd.row;
      col_r  <= head_cmd.col;
      last_r <= last_k;
      if (head_cmd.mode == MODE_FWD) begin
        value_r <= head_cmd.value;
        off_r   <= head_cmd.off;
        win_r   <= 1'b1;
      end else begin
        value_r <= hit ? head_cmd.value : '0;
        off_r   <= k_r;
        win_r   <= hit;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_mode   = mode_r;
  assign out_ch.result_value  = value_r;
  assign out_ch.out_row       = row_r;
  assign out_ch.out_col       = col_r;
  assign out_ch.window_offset = off_r;
  assign out_ch.is_winner     = win_r;
  assign out_ch.last          = last_r;

endmodule

### rtl/core/max_pool_2d_with_argmax_routing_core.sv
// Max pooling with argmax routing: one item accepted per cycle while the
// result queue has room. Items pass the index pipeline registers s0 to s3,
// the command queue and the output register of the result sequencer.
// A forward item gives at most one result; a backward item gives
// pool_rows*pool_cols results, one per cycle from the result sequencer unless stalled.
// Synchronous reset clears counters and queue and sets the default configuration; stores are not cleared.
module max_pool_2d_with_argmax_routing_core #(
  parameter int MAX_COLS     = mpr_pkg::DEF_MAX_COLS,
  parameter int MASK_ENTRIES = mpr_pkg::DEF_MASK_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mpr_in_if.sink                          in_ch,
  mpr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mpr_pkg::*;

  cfg_t cfg_r;
  logic [DIM_W-1:0]  dim_v;
  logic [POOL_W-1:0] pool_v;
  logic [DIM_W-1:0]  dim_c;
  logic [POOL_W-1:0] pool_c;
  logic [PCNT_W-1:0] cnt_c;

  always_comb begin
    dim_v  = cfg_wdata[DIM_W-1:0];
    pool_v = cfg_wdata[POOL_W-1:0];
    if (dim_v == '0)
      dim_c = 11'd1;
    else if (dim_v > 11'(MAX_DIM))
      dim_c = 11'(MAX_DIM);
    else
      dim_c = dim_v;
    if (pool_v == '0)
      pool_c = 4'd1;
    else if (pool_v > 4'(MAX_POOL))
      pool_c = 4'(MAX_POOL);
    else
      pool_c = pool_v;
    if (cfg_wdata == '0)
      cnt_c = 17'd1;
    else if (cfg_wdata > 17'd65536)
      cnt_c = 17'd65536;
    else
      cnt_c = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_rows  <= 11'd1;
      cfg_r.plane_cols  <= 11'd1;
      cfg_r.pool_rows   <= 4'd2;
      cfg_r.pool_cols   <= 4'd2;
      cfg_r.plane_count <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLANE_ROWS:  cfg_r.plane_rows  <= dim_c;
        CFG_PLANE_COLS:  cfg_r.plane_cols  <= dim_c;
        CFG_POOL_ROWS:   cfg_r.pool_rows   <= pool_c;
        CFG_POOL_COLS:   cfg_r.pool_cols   <= pool_c;
        CFG_PLANE_COUNT: cfg_r.plane_count <= cnt_c;
        default: ;
      endcase
    end
  end

  logic            push, pop, head_valid;
  cmd_t            push_cmd, head_cmd;
  logic [Q_CW-1:0] q_count;

  mpr_front #(
    .MAX_COLS     (MAX_COLS),
    .MASK_ENTRIES (MASK_ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_count (q_count),
    .push    (push),
    .cmd     (push_cmd)
  );

  mpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (head_valid),
    .count     (q_count)
  );

  mpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the max pooling core with argmax routing.
// Depends on mpr_pkg and the channel interfaces in mpr_if.sv.
module tb_top;
  import mpr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // Mirrors the pooling behavior and holds the results still owed by the block.
  class pool_scoreboard;
    typedef struct {
      logic                    mode;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        row;
      logic [CNT_W-1:0]        col;
      logic [OFF_W-1:0]        off;
      logic                    win;
      logic                    last;
    } pooled_t;

    int unsigned plane_rows, plane_cols, pool_rows, pool_cols, plane_count;
    int unsigned row_cnt, col_cnt, plane_cnt, pos_cnt;
    logic signed [VAL_W-1:0] col_max[MAX_DIM];
    logic [OFF_W-1:0] col_arg[MAX_DIM];
    logic [OFF_W-1:0] winner_mask[DEF_MASK_ENTRIES];
    bit col_seen[MAX_DIM];
    bit mask_seen[DEF_MASK_ENTRIES];
    pooled_t owed[$];
    int n_inputs, n_results, n_errors;

    function new();
      plane_rows = 1; plane_cols = 1; pool_rows = 2; pool_cols = 2; plane_count = 1;
      row_cnt = 0; col_cnt = 0; plane_cnt = 0; pos_cnt = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      case (idx)
        CFG_PLANE_ROWS:  plane_rows  = clamp(v & 'h7FF, 1, MAX_DIM);
        CFG_PLANE_COLS:  plane_cols  = clamp(v & 'h7FF, 1, MAX_DIM);
        CFG_POOL_ROWS:   pool_rows   = clamp(v & 'hF, 1, MAX_POOL);
        CFG_POOL_COLS:   pool_cols   = clamp(v & 'hF, 1, MAX_POOL);
        CFG_PLANE_COUNT: plane_count = clamp(v & 'h1FFFF, 1, 65536);
        default: ;
      endcase
    endfunction

    // True when the item would only read store entries that hold real data.
    function bit reads_written(bit m, bit f);
      int unsigned r, c, off;
      r = f ? 0 : row_cnt;
      c = f ? 0 : col_cnt;
      if (m == MODE_BWD) return mask_seen[f ? 0 : pos_cnt];
      off = (r % pool_rows) * pool_cols + c % pool_cols;
      return off == 0 || col_seen[(c / pool_cols) % MAX_DIM];
    endfunction

    function void step_grid(int unsigned cols, int unsigned rows);
      col_cnt++;
      if (col_cnt >= cols) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= rows) begin
          row_cnt = 0;
          plane_cnt++;
          if (plane_cnt >= plane_count) begin
            plane_cnt = 0;
            pos_cnt = 0;
          end
        end
      end
      col_cnt &= 'h3FF;
      row_cnt &= 'h3FF;
      plane_cnt &= 'hFFFF;
    endfunction

    function void bump_pos();
      pos_cnt = (pos_cnt + 1) % DEF_MASK_ENTRIES;
    endfunction

    function void note_input(bit m, bit f, logic signed [VAL_W-1:0] v);
      int unsigned wr, wc, oc, off, orows, ocols, total;
      pooled_t e;
      n_inputs++;
      if (f) begin
        row_cnt = 0; col_cnt = 0; plane_cnt = 0; pos_cnt = 0;
      end
      if (m == MODE_FWD) begin
        wr = row_cnt % pool_rows;
        wc = col_cnt % pool_cols;
        oc = (col_cnt / pool_cols) % MAX_DIM;
        off = wr * pool_cols + wc;
        if (off == 0 || v > col_max[oc]) begin
          col_max[oc] = v;
          col_arg[oc] = off;
          col_seen[oc] = 1;
        end
        if (wr == pool_rows - 1 && wc == pool_cols - 1 &&
            col_cnt < (plane_cols / pool_cols) * pool_cols &&
            row_cnt < (plane_rows / pool_rows) * pool_rows) begin
          e = '{MODE_FWD, col_max[oc], row_cnt / pool_rows, oc, col_arg[oc], 1'b1, 1'b1};
          owed.push_back(e);
          winner_mask[pos_cnt] = col_arg[oc];
          mask_seen[pos_cnt] = 1;
          bump_pos();
        end
        step_grid(plane_cols, plane_rows);
      end else begin
        orows = plane_rows / pool_rows;
        ocols = plane_cols / pool_cols;
        total = pool_rows * pool_cols;
        if (orows == 0) orows = 1;
        if (ocols == 0) ocols = 1;
        for (int unsigned k = 0; k < total; k++) begin
          e.mode = MODE_BWD;
          e.win = (k == winner_mask[pos_cnt]);
          e.value = e.win ? v : '0;
          e.row = row_cnt;
          e.col = col_cnt;
          e.off = k;
          e.last = (k == total - 1);
          owed.push_back(e);
        end
        bump_pos();
        step_grid(ocols, orows);
      end
    endfunction

    function void cmp(string name, longint exp, longint act);
      if (exp != act) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
        n_errors++;
      end
    endfunction

    function void check_result(logic md, logic signed [VAL_W-1:0] val, logic [CNT_W-1:0] r,
                               logic [CNT_W-1:0] c, logic [OFF_W-1:0] off, logic w,
                               logic lst);
      pooled_t e;
      n_results++;
      if (owed.size() == 0) begin
        $error("result transfer with nothing pending (value %0d)", val);
        n_errors++;
        return;
      end
      e = owed.pop_front();
      cmp("result_mode", e.mode, md);
      cmp("result_value", e.value, val);
      cmp("out_row", e.row, r);
      cmp("out_col", e.col, c);
      cmp("window_offset", e.off, off);
      cmp("is_winner", e.win, w);
      cmp("last", e.last, lst);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mpr_in_if  in_ch();
  mpr_out_if out_ch();

  max_pool_2d_with_argmax_routing_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pool_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int cycles;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_mode, out_ch.result_value, out_ch.out_row,
                      out_ch.out_col, out_ch.window_offset, out_ch.is_winner, out_ch.last);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Waits until no result is owed and in-flight items without results drain.
  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_regs(int unsigned plr, int unsigned plc, int unsigned pr,
                              int unsigned pc, int unsigned cnt);
    logic [CFG_IDX_W-1:0] idx[5];
    int unsigned val[5];
    idx = '{CFG_PLANE_ROWS, CFG_PLANE_COLS, CFG_POOL_ROWS, CFG_POOL_COLS, CFG_PLANE_COUNT};
    val = '{plr, plc, pr, pc, cnt};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one item and holds it until the transfer. Items that would read
  // never-written stores are turned into safe ones first.
  task automatic send(bit m, bit f, logic signed [VAL_W-1:0] v);
    if (!sb.reads_written(m, f)) f = 1;
    if (!sb.reads_written(m, f)) m = MODE_FWD;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.first <= f;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(m, f, v);
  endtask

  task automatic finish_items();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pass(int nfwd, int nbwd);
    for (int i = 0; i < nfwd; i++) send(MODE_FWD, i == 0, $urandom());
    for (int i = 0; i < nbwd; i++) send(MODE_BWD, i == 0, $urandom());
    finish_items();
  endtask

  task automatic noise(int n);
    for (int i = 0; i < n; i++) send($urandom_range(0, 1), $urandom_range(0, 3) == 0, $urandom());
    finish_items();
  endtask

  initial begin
    logic signed [VAL_W-1:0] acts[16];
    logic signed [VAL_W-1:0] grads[4];
    acts = '{-16'sd32768, -16'sd32768, 16'sd5, 16'sd32767, -16'sd32768, -16'sd32768,
             16'sd32767, 16'sd5, 16'sd0, -16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd0,
             16'sd1, 16'sd7};
    grads = '{16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_FWD;
    in_ch.first <= 1'b0;
    in_ch.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: the plane is smaller than the window, so nothing comes out.
    send(MODE_FWD, 1, -16'sd32768);
    send(MODE_FWD, 0, 16'sd32767);
    finish_items();

    // Directed 4x4 plane with ties and extremes, then gradients routed back.
    program_regs(4, 4, 2, 2, 1);
    for (int i = 0; i < 16; i++) send(MODE_FWD, i == 0, acts[i]);
    for (int i = 0; i < 4; i++) send(MODE_BWD, i == 0, grads[i]);
    finish_items();

    // 3x3 windows, then a 2x2 backward pass so some stored winners are stale.
    program_regs(3, 6, 3, 3, 1);
    pass(18, 2);
    program_regs(4, 4, 2, 2, 1);
    pass(0, 4);
    noise(6);

    // Unit windows over two planes; the result side holds off for a while.
    program_regs(2, 3, 1, 1, 2);
    pass(12, 0);
    drain();
    hold_req = 1;
    pass(0, 12);
    while (hold_req) @(posedge clk);

    // Largest window: every gradient fans out to 64 results.
    program_regs(8, 8, 8, 8, 1);
    pass(0, 3);

    // Sizes that leave a trailing row and column.
    program_regs(3, 4, 2, 3, 1);
    pass(12, 2);

    // Out-of-range register values that clamp; no idling from here on.
    quiet = 1;
    program_regs(0, 2047, 0, 15, 0);
    pass(8, 1);
    noise(4);

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Covered %0d input transfers and %0d result transfers", sb.n_inputs, sb.n_results);
    $display("across forward and backward passes, stale winners and clamped sizes.");
    if (sb.n_errors == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
